>>> rtl/smpq_pkg.sv
// smpq_pkg: shared types and codes for the stable min-priority queue.
// No dependencies; used by smpq_front, smpq_store and the top level.
package smpq_pkg;

	// Raw operation codes as they arrive on the input tuser field
	localparam logic [1:0] OPC_PUSH  = 2'd0;
	localparam logic [1:0] OPC_POP   = 2'd1;
	localparam logic [1:0] OPC_CLEAR = 2'd2;
	localparam logic [1:0] OPC_RSVD  = 2'd3;  // unused code, ignored

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int COST_W   = 24;
	localparam int PARENT_W = 31;
	localparam int OPER_W   = 16;

	// Command class after decode; the unused code becomes an ignore
	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_POP,
		CMD_CLEAR,
		CMD_IGNORE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t               op;
		logic [COST_W-1:0]     cost;
		logic [PARENT_W-1:0]   parent;
		logic [OPER_W-1:0]     oper;
	} cmd_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [PARENT_W-1:0]   parent;
		logic [OPER_W-1:0]     oper;
	} result_t;

endpackage

>>> rtl/stable_min_priority_queue_unit.sv
// stable_min_priority_queue_unit: top level of the stable min-priority queue.
// Depends on smpq_pkg, smpq_front and smpq_store.
//
// Usage:
//   Input channel s_axis: tuser carries the operation (push, pop, clear;
//   the unused code is ignored and answered ok). tdata carries the entry
//   to push: cost, parent state and operator index.
//   Output channel m_axis: one result transaction per input transaction.
//   tuser is the status (ok, pop on empty, push dropped because full),
//   tdata the popped parent state and operator, zero unless a pop succeeded.
//   Among equal costs, pops return entries in push order.
// Timing:
//   Sustained throughput is one transaction per cycle while results are taken;
//   the cell row sorts on insert with all cells comparing in parallel. The
//   command queue entry is written at the accepting edge; the cell row and
//   result register update when that command executes.
// Reset:
//   Clears the command queue, the occupancy and the result valid; entry
//   cells keep no reset and are never read beyond the occupancy.
// Stall:
//   A held result stops the cell row; the two-entry command queue then
//   fills and s_axis_tready drops.
module stable_min_priority_queue_unit #(
	parameter int CAPACITY  = 256,
	parameter int COST_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // cost[23:0], parent_state[54:24], operator_index[70:55]
	input  logic [1:0]  s_axis_tuser,   // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // popped_parent_state[30:0], popped_operator[46:31]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	logic               cmd_valid;
	logic               cmd_ready;
	smpq_pkg::cmd_t     cmd;
	smpq_pkg::result_t  res;

	// Front: decode and buffer
	smpq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opc    (s_axis_tuser),
		.in_cost   (s_axis_tdata[23:0]),
		.in_parent (s_axis_tdata[54:24]),
		.in_oper   (s_axis_tdata[70:55]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back: sorted cell row and result register
	smpq_store #(
		.CAPACITY  (CAPACITY),
		.COST_BITS (COST_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {1'b0, res.oper, res.parent};

endmodule

>>> rtl/smpq_front.sv
// smpq_front: accepts input transactions, decodes the operation and
// buffers commands in a two-entry queue. Depends on smpq_pkg.
module smpq_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_opc,
	input  logic [smpq_pkg::COST_W-1:0]   in_cost,
	input  logic [smpq_pkg::PARENT_W-1:0] in_parent,
	input  logic [smpq_pkg::OPER_W-1:0]   in_oper,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output smpq_pkg::cmd_t       cmd
);

	smpq_pkg::cmd_t  buf_q [2];
	smpq_pkg::cmd_t  dec;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            wr_en;
	logic            rd_en;

	always_comb begin
		unique case (in_opc)
			smpq_pkg::OPC_PUSH:  dec.op = smpq_pkg::CMD_PUSH;
			smpq_pkg::OPC_POP:   dec.op = smpq_pkg::CMD_POP;
			smpq_pkg::OPC_CLEAR: dec.op = smpq_pkg::CMD_CLEAR;
			default:             dec.op = smpq_pkg::CMD_IGNORE;
		endcase
		dec.cost   = in_cost;
		dec.parent = in_parent;
		dec.oper   = in_oper;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_ptr_q];
	assign wr_en     = in_valid && in_ready;
	assign rd_en     = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("front queue count out of range");
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en == rd_en) |=> $stable(cnt_q)) else $error("front count moved");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("front pointers inconsistent");

endmodule

>>> rtl/smpq_store.sv
// smpq_store: sorted row of entry cells with the result register.
// Executes one command per cycle while the result register is free or being taken. Depends on smpq_pkg.
module smpq_store #(
	parameter int CAPACITY  = 256,
	parameter int COST_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  smpq_pkg::cmd_t      cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output smpq_pkg::result_t   res
);

	localparam int KEY_W = (COST_BITS < smpq_pkg::COST_W) ? COST_BITS : smpq_pkg::COST_W;
	localparam int OCC_W = $clog2(CAPACITY + 1);

	logic [KEY_W-1:0]              cost_q   [CAPACITY];
	logic [smpq_pkg::PARENT_W-1:0] parent_q [CAPACITY];
	logic [smpq_pkg::OPER_W-1:0]   oper_q   [CAPACITY];
	logic [CAPACITY-1:0]           le;
	logic [OCC_W-1:0]              occ_q;
	logic [KEY_W-1:0]              key;
	logic                          exec;
	logic                          full;
	logic                          empty;
	logic                          do_push;
	logic                          do_pop;
	smpq_pkg::result_t             res_d;
	smpq_pkg::result_t             res_q;
	logic                          res_valid_q;

	assign key       = cmd.cost[KEY_W-1:0];
	assign full      = (occ_q == OCC_W'(CAPACITY));
	assign empty     = (occ_q == '0);
	assign cmd_ready = !res_valid_q || res_ready;
	assign exec      = cmd_valid && cmd_ready;
	assign do_push   = exec && (cmd.op == smpq_pkg::CMD_PUSH) && !full;
	assign do_pop    = exec && (cmd.op == smpq_pkg::CMD_POP) && !empty;

	// Each cell sees whether it stays ahead of the incoming key
	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			assign le[i] = (OCC_W'(i) < occ_q) && (cost_q[i] <= key);

			always_ff @(posedge clk) begin
				if (do_push && !le[i]) begin
					if (i == 0) begin
						cost_q[i]   <= key;
						parent_q[i] <= cmd.parent;
						oper_q[i]   <= cmd.oper;
					end else begin
						if (le[(i == 0) ? 0 : i-1]) begin
							cost_q[i]   <= key;
							parent_q[i] <= cmd.parent;
							oper_q[i]   <= cmd.oper;
						end else begin
							cost_q[i]   <= cost_q[(i == 0) ? 0 : i-1];
							parent_q[i] <= parent_q[(i == 0) ? 0 : i-1];
							oper_q[i]   <= oper_q[(i == 0) ? 0 : i-1];
						end
					end
				end else if (do_pop && (i < CAPACITY-1)) begin
					cost_q[i]   <= cost_q[(i < CAPACITY-1) ? i+1 : i];
					parent_q[i] <= parent_q[(i < CAPACITY-1) ? i+1 : i];
					oper_q[i]   <= oper_q[(i < CAPACITY-1) ? i+1 : i];
				end
			end
		end
	endgenerate

	always_comb begin
		res_d.status = smpq_pkg::ST_OK;
		res_d.parent = '0;
		res_d.oper   = '0;
		unique case (cmd.op)
			smpq_pkg::CMD_PUSH: begin
				if (full) begin
					res_d.status = smpq_pkg::ST_FULL;
				end
			end
			smpq_pkg::CMD_POP: begin
				if (empty) begin
					res_d.status = smpq_pkg::ST_EMPTY;
				end else begin
					res_d.parent = parent_q[0];
					res_d.oper   = oper_q[0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (exec && cmd.op == smpq_pkg::CMD_CLEAR) begin
				occ_q <= '0;
			end else if (do_push) begin
				occ_q <= occ_q + 1'b1;
			end else if (do_pop) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY)) else $error("occupancy over capacity");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && cmd.op == smpq_pkg::CMD_CLEAR) |=> (occ_q == '0))
		else $error("clear left entries");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && cmd.op == smpq_pkg::CMD_PUSH && full) |=> $stable(occ_q))
		else $error("push into full store changed occupancy");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> res_valid_q) else $error("executed command gave no result");

endmodule

>>> test/tb_stable_min_priority_queue_unit.sv
// Testbench for stable_min_priority_queue_unit: random and directed push/pop/clear
// traffic checked against an in-bench sorted-store predictor. Depends on smpq_pkg.
`timescale 1ns / 100ps

module tb_stable_min_priority_queue_unit;

	localparam int CAP      = 256;
	localparam int COST_W   = smpq_pkg::COST_W;
	localparam int PARENT_W = smpq_pkg::PARENT_W;
	localparam int OPER_W   = smpq_pkg::OPER_W;

	typedef struct {
		logic [1:0]          opc;
		logic [COST_W-1:0]   cost;
		logic [PARENT_W-1:0] parent;
		logic [OPER_W-1:0]   oper;
	} queue_cmd_t;

	typedef struct {
		logic [1:0]          status;
		logic [PARENT_W-1:0] parent;
		logic [OPER_W-1:0]   oper;
	} queue_reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;   // cost[23:0], parent_state[54:24], operator_index[70:55]
	logic [1:0]  s_axis_tuser;   // operation[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // popped_parent_state[30:0], popped_operator[46:31]
	logic [1:0]  m_axis_tuser;   // status[1:0]

	stable_min_priority_queue_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	queue_cmd_t   pending_cmds[$];
	queue_reply_t expected_replies[$];
	int           mismatch_count = 0;
	bit           quiet_phase = 0;     // no idling in this stretch
	int           sink_hold = 0;       // long receiver hold-off, in cycles
	bit           src_pause = 0;       // sender waits for drain

	// predictor copy of the sorted store
	logic [COST_W-1:0]   pq_cost[CAP];
	logic [PARENT_W-1:0] pq_parent[CAP];
	logic [OPER_W-1:0]   pq_oper[CAP];
	int                  pq_count = 0;

	function automatic queue_reply_t predict_reply(queue_cmd_t c);
		queue_reply_t r;
		int pos;
		r.status = smpq_pkg::ST_OK; r.parent = '0; r.oper = '0;
		case (c.opc)
			smpq_pkg::OPC_PUSH: begin
				if (pq_count >= CAP) begin
					r.status = smpq_pkg::ST_FULL;
				end else begin
					pos = 0;
					// equal costs stay in push order
					while (pos < pq_count && pq_cost[pos] <= c.cost) pos++;
					for (int i = pq_count; i > pos; i--) begin
						pq_cost[i] = pq_cost[i-1];
						pq_parent[i] = pq_parent[i-1];
						pq_oper[i] = pq_oper[i-1];
					end
					pq_cost[pos] = c.cost; pq_parent[pos] = c.parent; pq_oper[pos] = c.oper;
					pq_count++;
				end
			end
			smpq_pkg::OPC_POP: begin
				if (pq_count == 0) begin
					r.status = smpq_pkg::ST_EMPTY;
				end else begin
					r.parent = pq_parent[0]; r.oper = pq_oper[0];
					for (int i = 1; i < pq_count; i++) begin
						pq_cost[i-1] = pq_cost[i];
						pq_parent[i-1] = pq_parent[i];
						pq_oper[i-1] = pq_oper[i];
					end
					pq_count--;
				end
			end
			smpq_pkg::OPC_CLEAR: pq_count = 0;
			default: ;  // unused code: ignored
		endcase
		return r;
	endfunction

	function automatic queue_cmd_t make_cmd(logic [1:0] opc, logic [COST_W-1:0] cost,
			logic [PARENT_W-1:0] parent, logic [OPER_W-1:0] oper);
		queue_cmd_t c;
		c.opc = opc; c.cost = cost; c.parent = parent; c.oper = oper;
		return c;
	endfunction

	function automatic queue_cmd_t rand_push(int cost_span);
		return make_cmd(smpq_pkg::OPC_PUSH,
			(cost_span == 0) ? COST_W'($urandom) : COST_W'($urandom_range(cost_span)),
			PARENT_W'($urandom), OPER_W'($urandom));
	endfunction

	function automatic queue_cmd_t rand_other(logic [1:0] opc);
		return make_cmd(opc, COST_W'($urandom), PARENT_W'($urandom), OPER_W'($urandom));
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatch_count++;
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid) expected_replies.push_back(predict_reply(pending_cmds.pop_front()));
				if (pending_cmds.size() != 0 && !(src_pause && expected_replies.size() != 0)
						&& (quiet_phase || $urandom_range(99) >= 14)) begin
					s_axis_tvalid <= 1;
					s_axis_tuser <= pending_cmds[0].opc;
					s_axis_tdata <= {1'b0, pending_cmds[0].oper, pending_cmds[0].parent,
						pending_cmds[0].cost};
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		queue_reply_t want;
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected result", {m_axis_tuser, m_axis_tdata}, '0);
				end else begin
					want = expected_replies.pop_front();
					if (m_axis_tuser != want.status)
						report_mismatch("status", m_axis_tuser, want.status);
					if (m_axis_tdata[30:0] != want.parent)
						report_mismatch("parent", m_axis_tdata[30:0], want.parent);
					if (m_axis_tdata[46:31] != want.oper)
						report_mismatch("operator", m_axis_tdata[46:31], want.oper);
				end
			end
			if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= quiet_phase || $urandom_range(99) >= 14;
			end
		end
	end

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		int span;
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0; m_axis_tready = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: empty pop, extremes, stable ties, unused code, clear
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_POP, '0, '0, '0));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_PUSH, '1, '1, '1));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_PUSH, '0, '0, '0));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_PUSH, 24'd5, 31'h1, 16'h1));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_PUSH, 24'd5, 31'h2, 16'h2));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_PUSH, 24'd5, 31'h3, 16'h3));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_RSVD, '1, '1, '1));
		for (int i = 0; i < 6; i++)
			pending_cmds.push_back(make_cmd(smpq_pkg::OPC_POP, '1, '1, '1));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_PUSH, 24'h800000, 31'h40000000,
			16'h8000));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_PUSH, 24'h7, 31'h55555555, 16'haaaa));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_CLEAR, '1, '1, '1));
		pending_cmds.push_back(make_cmd(smpq_pkg::OPC_POP, '0, '0, '0));
		wait_drained();

		// fill past capacity with the receiver held off: input must stall
		sink_hold = 300;
		for (int i = 0; i < CAP + 4; i++) pending_cmds.push_back(rand_push(15));
		wait_drained();
		for (int i = 0; i < CAP + 2; i++)
			pending_cmds.push_back(make_cmd(smpq_pkg::OPC_POP, '0, '0, '0));
		wait_drained();

		// random phases alternating push-heavy and pop-heavy, some with small cost spans for ties
		for (int ph = 0; ph < 12; ph++) begin
			quiet_phase = (ph == 4);
			span = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 255);
			for (int i = 0; i < 68; i++) begin
				n = $urandom_range(99);
				if (n < ((ph % 2) ? 35 : 60)) pending_cmds.push_back(rand_push(span));
				else if (n < 96) pending_cmds.push_back(rand_other(smpq_pkg::OPC_POP));
				else if (n < 98) pending_cmds.push_back(rand_other(smpq_pkg::OPC_CLEAR));
				else pending_cmds.push_back(rand_other(smpq_pkg::OPC_RSVD));
			end
			if (ph == 6) begin
				src_pause = 1;
				wait_drained();
				src_pause = 0;
			end
			wait_drained();
		end
		quiet_phase = 0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/smpq_pkg.sv
rtl/smpq_front.sv
rtl/smpq_store.sv
rtl/stable_min_priority_queue_unit.sv
test/tb_stable_min_priority_queue_unit.sv
